@@ rtl/bb3_pkg.sv @@
// Shared types, sizes and the reciprocal table of the 3x3 box blur.
`default_nettype none
package bb3_pkg;

	// Frame limits and the widths that follow from them.
	localparam int MAX_WIDTH  = 2048;
	localparam int MAX_HEIGHT = 2048;
	localparam int CFG_W      = 12;
	localparam int WDIM_W     = $clog2(MAX_WIDTH + 1);
	localparam int HDIM_W     = $clog2(MAX_HEIGHT + 1);
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT + 2);
	localparam int COUNT_W    = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_WIDTH + 1);
	localparam int STEP_W     = $clog2(COUNT_W);
	localparam int PIX_W      = 24;
	localparam int SUM_W      = 12;
	localparam int RECIP_W    = 17;
	localparam int RECIP_SH   = 16;
	localparam int PROD_W     = SUM_W + RECIP_W;
	localparam int CHAN_MAX   = 255;

	// Reset values of the frame registers.
	localparam logic [CFG_W-1:0] WIDTH_RST  = CFG_W'(640);
	localparam logic [CFG_W-1:0] HEIGHT_RST = CFG_W'(480);

	// Register indexes on the configuration port.
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	// Opcode of an input word.
	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	typedef struct packed {
		logic       opcode;
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
	} in_word_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic       frame_last;
	} out_word_t;

	// Per-word control that travels down the pipeline with the pixel.
	typedef struct packed {
		logic res;
		logic top;
		logic bot;
		logic left;
		logic right;
		logic last;
	} win_flags_t;

	// Position recount after a configuration write.
	typedef enum logic [1:0] {
		RC_IDLE,
		RC_WAIT,
		RC_CHECK,
		RC_DIV
	} rc_state_t;

	// Fixed-point reciprocal of the tap count, scaled by 2^RECIP_SH.
	// Exact after truncation for every sum a window can produce.
	function automatic logic [RECIP_W-1:0] recip(input logic [3:0] n);
		logic [RECIP_W-1:0] k;
		case (n)
			4'd1:    k = RECIP_W'(65536);
			4'd2:    k = RECIP_W'(32768);
			4'd3:    k = RECIP_W'(21846);
			4'd4:    k = RECIP_W'(16384);
			4'd6:    k = RECIP_W'(10923);
			4'd9:    k = RECIP_W'(7282);
			default: k = RECIP_W'(65536);
		endcase
		return k;
	endfunction

endpackage
`default_nettype wire

@@ rtl/box_blur_3x3.sv @@
// 3x3 box blur over an RGB raster stream, normalized by the in-frame tap count.
// The block takes one pixel word per clock and gives one blurred word per clock once
// the stream is one row plus one pixel deep, while neither blur_stall nor a recount
// holds it; a result passes the stage 1, window, stage 3 and output registers. Two
// line memories of MAX_WIDTH entries hold the rows above, read at the column of each
// incoming word. After the last pixel of a frame, send image_width+1 drain words
// (opcode 1); frame_last marks the final result. Writing a frame register holds off
// pixel words while the position in the frame is recounted for the new geometry by a
// one-bit-per-cycle divider, or while it is found to lie past the new frame end, in
// which case the frame restarts with the next word. The line memories are not cleared;
// entries that were never written only feed taps that lie outside the frame.
`default_nettype none
module box_blur_3x3 (
	input  wire                    clk,
	input  wire                    arst_n,
	// Pixel input channel
	input  wire                    pix_valid,
	output logic                   pix_stall,
	input  wire bb3_pkg::in_word_t pix_data,
	// Blurred output channel
	output logic                   blur_valid,
	input  wire                    blur_stall,
	output bb3_pkg::out_word_t     blur_data,
	// Configuration port
	input  wire                    psel,
	input  wire                    penable,
	input  wire                    pwrite,
	input  wire  [2:0]             paddr,
	input  wire  [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);

	localparam int CW = bb3_pkg::COUNT_W;
	localparam int WW = bb3_pkg::WDIM_W;
	localparam int HW = bb3_pkg::HDIM_W;
	localparam int KW = bb3_pkg::COL_W;
	localparam int RW = bb3_pkg::ROW_W;
	localparam int PW = bb3_pkg::PIX_W;
	localparam int SW = bb3_pkg::SUM_W;
	localparam int STEPW = bb3_pkg::STEP_W;

	// Configuration registers and the derived frame geometry.
	logic [bb3_pkg::CFG_W-1:0] width_q, height_q;
	logic [WW-1:0]             w_eff;
	logic [HW-1:0]             h_eff;
	logic [CW-1:0]             total_m1_q;
	logic                      cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= bb3_pkg::WIDTH_RST;
			height_q <= bb3_pkg::HEIGHT_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == bb3_pkg::REG_WIDTH) begin
				width_q <= pwdata[bb3_pkg::CFG_W-1:0];
			end else begin
				height_q <= pwdata[bb3_pkg::CFG_W-1:0];
			end
		end
	end

	always_comb begin
		if (paddr[2] == bb3_pkg::REG_WIDTH) begin
			prdata = 32'(width_q);
		end else begin
			prdata = 32'(height_q);
		end
	end

	// Zero counts as one, and anything past MAX_WIDTH or MAX_HEIGHT saturates.
	always_comb begin
		if (width_q == '0) begin
			w_eff = WW'(1);
		end else if (32'(width_q) > bb3_pkg::MAX_WIDTH) begin
			w_eff = WW'(bb3_pkg::MAX_WIDTH);
		end else begin
			w_eff = WW'(width_q);
		end
		if (height_q == '0) begin
			h_eff = HW'(1);
		end else if (32'(height_q) > bb3_pkg::MAX_HEIGHT) begin
			h_eff = HW'(bb3_pkg::MAX_HEIGHT);
		end else begin
			h_eff = HW'(height_q);
		end
	end

	// Position of the frame's final word, one multiply per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_m1_q <= CW'(640 * 480 + 640);
		end else begin
			total_m1_q <= CW'(w_eff) * CW'(h_eff) + CW'(w_eff);
		end
	end

	// Position of the next word: running count, column and row.
	logic [CW-1:0] count_q, count_eff;
	logic [KW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic          is_last;

	// Recount sequencer state.
	bb3_pkg::rc_state_t rc_state_q, rc_state_nx;
	logic [STEPW-1:0]   step_q;
	logic [CW-1:0]      quo_q, quo_nx;
	logic [WW-1:0]      rem_q, rem_nx;
	logic [WW:0]        trial;
	logic               busy, over, rc_clr, div_init, div_step, div_done;

	assign over = count_q > total_m1_q;

	always_comb begin
		rc_state_nx = rc_state_q;
		case (rc_state_q)
			bb3_pkg::RC_IDLE:  rc_state_nx = bb3_pkg::RC_IDLE;
			bb3_pkg::RC_WAIT:  rc_state_nx = bb3_pkg::RC_CHECK;
			bb3_pkg::RC_CHECK: rc_state_nx = over ? bb3_pkg::RC_IDLE : bb3_pkg::RC_DIV;
			bb3_pkg::RC_DIV: begin
				if (step_q == STEPW'(CW - 1)) begin
					rc_state_nx = bb3_pkg::RC_IDLE;
				end
			end
			default:           rc_state_nx = bb3_pkg::RC_IDLE;
		endcase
		if (cfg_wr) begin
			rc_state_nx = bb3_pkg::RC_WAIT;
		end
	end

	always_comb begin
		busy     = rc_state_q != bb3_pkg::RC_IDLE;
		rc_clr   = (rc_state_q == bb3_pkg::RC_CHECK) && over && !cfg_wr;
		div_init = (rc_state_q == bb3_pkg::RC_CHECK) && !over;
		div_step = rc_state_q == bb3_pkg::RC_DIV;
		div_done = div_step && (step_q == STEPW'(CW - 1)) && !cfg_wr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rc_state_q <= bb3_pkg::RC_IDLE;
			step_q     <= '0;
		end else begin
			rc_state_q <= rc_state_nx;
			if (div_init) begin
				step_q <= '0;
			end else if (div_step) begin
				step_q <= step_q + STEPW'(1);
			end
		end
	end

	// Restoring division of the word count by the width, one quotient bit a cycle.
	always_comb begin
		trial = {rem_q, quo_q[CW-1]};
		if (trial >= (WW+1)'(w_eff)) begin
			rem_nx = WW'(trial - (WW+1)'(w_eff));
			quo_nx = {quo_q[CW-2:0], 1'b1};
		end else begin
			rem_nx = trial[WW-1:0];
			quo_nx = {quo_q[CW-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (div_init) begin
			quo_q <= count_q;
			rem_q <= '0;
		end else if (div_step) begin
			quo_q <= quo_nx;
			rem_q <= rem_nx;
		end
	end

	// Pipeline flow control: each stage moves when the one after it frees up.
	logic valid_s1, valid_s2, valid_s3, out_valid_q;
	logic rdy1, rdy2, rdy3, ready_out, go1, go2, go3, acc;

	assign ready_out = !out_valid_q || !blur_stall;
	assign rdy3      = !valid_s3 || ready_out;
	assign go3       = valid_s3 && ready_out;
	assign rdy2      = !valid_s2 || rdy3;
	assign go2       = valid_s2 && rdy3;
	assign rdy1      = !valid_s1 || rdy2;
	assign go1       = valid_s1 && rdy2;
	assign pix_stall = busy || !rdy1;
	assign acc       = pix_valid && !pix_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= acc;
			if (rdy2) valid_s2 <= go1;
			if (rdy3) valid_s3 <= go2;
		end
	end

	// A count left past the frame end by a geometry change counts as zero.
	assign count_eff = over ? '0 : count_q;
	assign is_last   = count_eff == total_m1_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			col_q   <= '0;
			row_q   <= '0;
		end else if (acc) begin
			if (is_last) begin
				count_q <= '0;
				col_q   <= '0;
				row_q   <= '0;
			end else begin
				count_q <= count_eff + CW'(1);
				if (WW'(col_q) == w_eff - WW'(1)) begin
					col_q <= '0;
					row_q <= row_q + RW'(1);
				end else begin
					col_q <= col_q + KW'(1);
				end
			end
		end else if (rc_clr) begin
			col_q   <= '0;
			row_q   <= '0;
		end else if (div_done) begin
			col_q <= rem_nx[KW-1:0];
			row_q <= quo_nx[RW-1:0];
		end
	end

	// Output position and frame-edge masks of the word being accepted.
	bb3_pkg::win_flags_t flags_in;
	always_comb begin
		flags_in.res  = (row_q >= RW'(2)) || ((row_q == RW'(1)) && (col_q != '0));
		flags_in.last = is_last;
		if (col_q == '0) begin
			flags_in.top   = row_q >= RW'(3);
			flags_in.bot   = row_q <= RW'(h_eff);
			flags_in.left  = w_eff >= WW'(2);
			flags_in.right = 1'b0;
		end else begin
			flags_in.top   = row_q >= RW'(2);
			flags_in.bot   = row_q < RW'(h_eff);
			flags_in.left  = col_q >= KW'(2);
			flags_in.right = WW'(col_q) < w_eff;
		end
	end

	// Stage 1: line memory reads and the incoming pixel.
	logic [PW-1:0]       row_a_mem [bb3_pkg::MAX_WIDTH];
	logic [PW-1:0]       row_b_mem [bb3_pkg::MAX_WIDTH];
	logic [PW-1:0]       pix_in, a_rd_s1, b_rd_s1, pix_s1, fwd_pix_s1;
	logic [KW-1:0]       col_s1;
	logic                fwd_s1;
	bb3_pkg::win_flags_t flags_s1;
	logic [PW-1:0]       above, older;

	assign pix_in = (pix_data.opcode == bb3_pkg::OP_DRAIN) ? '0 :
		{pix_data.red_in, pix_data.green_in, pix_data.blue_in};

	// The row directly above: read the old entry, store the new pixel.
	always_ff @(posedge clk) begin
		if (acc) begin
			a_rd_s1        <= row_a_mem[col_q];
			row_a_mem[col_q] <= pix_in;
		end
	end

	// The row two above is written one stage later with what was read above.
	always_ff @(posedge clk) begin
		if (acc) begin
			b_rd_s1 <= row_b_mem[col_q];
		end
		if (go1) begin
			row_b_mem[col_s1] <= above;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			pix_s1     <= pix_in;
			col_s1     <= col_q;
			flags_s1   <= flags_in;
			// A one-pixel-wide frame reads the entry the previous word is writing.
			fwd_s1     <= valid_s1 && go1 && (col_s1 == col_q);
			fwd_pix_s1 <= a_rd_s1;
		end
	end

	assign above = a_rd_s1;
	assign older = fwd_s1 ? fwd_pix_s1 : b_rd_s1;

	// Stage 2: the 3x3 window shifts in one new column.
	logic [PW-1:0]       win_q [9];
	bb3_pkg::win_flags_t flags_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 9; k++) begin
				win_q[k] <= '0;
			end
		end else if (go1) begin
			for (int i = 0; i < 3; i++) begin
				win_q[i*3]     <= win_q[i*3 + 1];
				win_q[i*3 + 1] <= win_q[i*3 + 2];
			end
			win_q[2] <= older;
			win_q[5] <= above;
			win_q[8] <= pix_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (go1) begin
			flags_s2 <= flags_s1;
		end
	end

	// Stage 3: masked channel sums and the reciprocal of the tap count.
	logic [2:0]               row_ok, col_ok;
	logic [SW-1:0]            sum_r, sum_g, sum_b;
	logic [1:0]               rows, cols;
	logic [3:0]               taps;
	logic [SW-1:0]            sum_r_s3, sum_g_s3, sum_b_s3;
	logic [bb3_pkg::RECIP_W-1:0] recip_s3;
	logic                     res_s3, last_s3;

	always_comb begin
		row_ok = {flags_s2.bot, 1'b1, flags_s2.top};
		col_ok = {flags_s2.right, 1'b1, flags_s2.left};
		rows   = 2'd1 + {1'b0, flags_s2.top} + {1'b0, flags_s2.bot};
		cols   = 2'd1 + {1'b0, flags_s2.left} + {1'b0, flags_s2.right};
		taps   = {2'b00, rows} * {2'b00, cols};
		sum_r  = '0;
		sum_g  = '0;
		sum_b  = '0;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				if (row_ok[i] && col_ok[j]) begin
					sum_r = sum_r + SW'(win_q[i*3 + j][23:16]);
					sum_g = sum_g + SW'(win_q[i*3 + j][15:8]);
					sum_b = sum_b + SW'(win_q[i*3 + j][7:0]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go2) begin
			sum_r_s3 <= sum_r;
			sum_g_s3 <= sum_g;
			sum_b_s3 <= sum_b;
			recip_s3 <= bb3_pkg::recip(taps);
			res_s3   <= flags_s2.res;
			last_s3  <= flags_s2.last;
		end
	end

	// Output: multiply by the reciprocal, truncate and clamp.
	typedef bb3_pkg::out_word_t out_word_t_local;
	logic [bb3_pkg::PROD_W-1:0] prod_r, prod_g, prod_b;
	out_word_t_local            out_nx;

	function automatic logic [7:0] clamp8(input logic [bb3_pkg::PROD_W-1:0] p);
		logic [bb3_pkg::PROD_W-bb3_pkg::RECIP_SH-1:0] m;
		m = p[bb3_pkg::PROD_W-1:bb3_pkg::RECIP_SH];
		if (32'(m) > bb3_pkg::CHAN_MAX) begin
			return 8'(bb3_pkg::CHAN_MAX);
		end
		return m[7:0];
	endfunction

	always_comb begin
		prod_r            = bb3_pkg::PROD_W'(sum_r_s3) * bb3_pkg::PROD_W'(recip_s3);
		prod_g            = bb3_pkg::PROD_W'(sum_g_s3) * bb3_pkg::PROD_W'(recip_s3);
		prod_b            = bb3_pkg::PROD_W'(sum_b_s3) * bb3_pkg::PROD_W'(recip_s3);
		out_nx.red_out    = clamp8(prod_r);
		out_nx.green_out  = clamp8(prod_g);
		out_nx.blue_out   = clamp8(prod_b);
		out_nx.frame_last = last_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ready_out) begin
			out_valid_q <= go3 && res_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (go3) begin
			blur_data <= out_nx;
		end
	end

	assign blur_valid = out_valid_q;

endmodule
`default_nettype wire
